// File: design/sfd_pkg.sv
// Package for the serial frame deframer.
// Holds sizing constants, register codes, the controller state type and the result struct.
// No dependencies.
package sfd_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd85;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET   = 6'd32;

    typedef enum logic {
        REG_START_MARKER = 1'b0,
        REG_MAX_LENGTH   = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LENGTH,
        ST_DATA,
        ST_CHECK,
        ST_READ,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic [LEN_W-1:0]  frame_length;
        logic [ADDR_W-1:0] byte_position;
        logic [BYTE_W-1:0] payload_byte;
        logic              last_of_frame;
    } t_result;

endpackage

// File: design/sfd_payload_mem.sv
// Payload store of the serial frame deframer: one write port, one registered read port.
// Depends on sfd_pkg for the depth and byte width.
module sfd_payload_mem (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [sfd_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [sfd_pkg::BYTE_W-1:0]  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [sfd_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic [sfd_pkg::BYTE_W-1:0]  o_rd_data
);
    import sfd_pkg::*;

    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/sfd_out_reg.sv
// Output register of the serial frame deframer, holding one result request under stall.
// Depends on sfd_pkg for the result struct.
module sfd_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  sfd_pkg::t_result            i_result,
    output logic                        o_free,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [sfd_pkg::LEN_W-1:0]   o_frame_length,
    output logic [sfd_pkg::ADDR_W-1:0]  o_byte_position,
    output logic [sfd_pkg::BYTE_W-1:0]  o_payload_byte,
    output logic                        o_last_of_frame
);
    import sfd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_free) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_frame_length  = r_result.frame_length;
    assign o_byte_position = r_result.byte_position;
    assign o_payload_byte  = r_result.payload_byte;
    assign o_last_of_frame = r_result.last_of_frame;

endmodule

// File: design/serial_frame_deframer.sv
// Serial frame deframer top level: frame parser, payload store readout and register port.
// Depends on sfd_pkg, sfd_payload_mem and sfd_out_reg.
// Received bytes are taken one per cycle while a frame is parsed and stored.
// After a matching checksum the input stalls and each result is read out through the
// READ state, which reads the payload store, and the LOAD state, which loads the output
// register and waits while it is stalled. Synchronous active-low reset returns to
// hunting with registers at their defaults; the payload store is not cleared.
module serial_frame_deframer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfd_pkg::PADDR_W-1:0]  paddr,
    input  logic [sfd_pkg::PDATA_W-1:0]  pwdata,
    output logic [sfd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_rx_valid,
    output logic                         o_rx_stall,
    input  logic [sfd_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sfd_pkg::LEN_W-1:0]    o_frame_length,
    output logic [sfd_pkg::ADDR_W-1:0]   o_byte_position,
    output logic [sfd_pkg::BYTE_W-1:0]   o_payload_byte,
    output logic                         o_last_of_frame
);
    import sfd_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [BYTE_W-1:0] r_start_marker;
    logic [LEN_W-1:0]  r_max_length;
    logic [LEN_W-1:0]  r_exp_len;
    logic [LEN_W-1:0]  n_exp_len;
    logic [LEN_W-1:0]  r_cnt;
    logic [LEN_W-1:0]  n_cnt;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] n_sum;
    logic [LEN_W-1:0]  r_idx;
    logic [LEN_W-1:0]  n_idx;

    logic              cfg_wr;
    t_reg_index        cfg_sel;
    logic              rx_accept;
    logic [LEN_W-1:0]  eff_max;
    logic [LEN_W-1:0]  cnt_inc;
    logic [LEN_W-1:0]  idx_inc;
    logic              rd_last;
    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [BYTE_W-1:0] mem_rd_data;
    logic              out_free;
    logic              out_load;
    t_result           out_result;

    assign pready  = 1'b1;
    assign cfg_sel = t_reg_index'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_sel)
            REG_START_MARKER: prdata = PDATA_W'(r_start_marker);
            REG_MAX_LENGTH:   prdata = PDATA_W'(r_max_length);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RESET;
            r_max_length   <= MAX_LENGTH_RESET;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_START_MARKER: r_start_marker <= pwdata[BYTE_W-1:0];
                REG_MAX_LENGTH:   r_max_length   <= pwdata[LEN_W-1:0];
                default:          r_start_marker <= r_start_marker;
            endcase
        end
    end

    assign eff_max   = (r_max_length > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                            : r_max_length;
    assign rx_accept = i_rx_valid && !o_rx_stall;
    assign cnt_inc   = r_cnt + LEN_W'(1);
    assign idx_inc   = r_idx + LEN_W'(1);
    assign rd_last   = (r_exp_len == '0) || (idx_inc == r_exp_len);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_HUNT: begin
                if (rx_accept && i_rx_byte == r_start_marker) begin
                    n_state = ST_LENGTH;
                end
            end
            ST_LENGTH: begin
                if (rx_accept) begin
                    if (i_rx_byte > BYTE_W'(eff_max)) begin
                        n_state = ST_HUNT;
                    end else if (i_rx_byte == '0) begin
                        n_state = ST_CHECK;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (rx_accept && cnt_inc >= r_exp_len) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (rx_accept) begin
                    n_state = (i_rx_byte == r_sum) ? ST_READ : ST_HUNT;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_state = rd_last ? ST_HUNT : ST_READ;
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    always_comb begin
        o_rx_stall = 1'b0;
        mem_wr_en  = 1'b0;
        mem_rd_en  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_HUNT, ST_LENGTH, ST_CHECK: begin
                o_rx_stall = 1'b0;
            end
            ST_DATA: begin
                mem_wr_en = rx_accept;
            end
            ST_READ: begin
                o_rx_stall = 1'b1;
                mem_rd_en  = 1'b1;
            end
            ST_LOAD: begin
                o_rx_stall = 1'b1;
                out_load   = out_free;
            end
            default: begin
                o_rx_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_exp_len = r_exp_len;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_idx     = r_idx;
        case (r_state)
            ST_LENGTH: begin
                if (rx_accept && i_rx_byte <= BYTE_W'(eff_max)) begin
                    n_exp_len = i_rx_byte[LEN_W-1:0];
                    n_cnt     = '0;
                    n_sum     = '0;
                end
            end
            ST_DATA: begin
                if (rx_accept) begin
                    n_cnt = cnt_inc;
                    n_sum = r_sum + i_rx_byte;
                end
            end
            ST_CHECK: begin
                n_idx = '0;
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_idx = idx_inc;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_HUNT;
            r_exp_len <= '0;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_exp_len <= n_exp_len;
            r_cnt     <= n_cnt;
            r_sum     <= n_sum;
            r_idx     <= n_idx;
        end
    end

    always_comb begin
        if (r_exp_len == '0) begin
            out_result.frame_length  = '0;
            out_result.byte_position = '0;
            out_result.payload_byte  = '0;
            out_result.last_of_frame = 1'b1;
        end else begin
            out_result.frame_length  = r_exp_len;
            out_result.byte_position = r_idx[ADDR_W-1:0];
            out_result.payload_byte  = mem_rd_data;
            out_result.last_of_frame = rd_last;
        end
    end

    sfd_payload_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_cnt[ADDR_W-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (mem_rd_data)
    );

    sfd_out_reg u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (out_load),
        .i_result        (out_result),
        .o_free          (out_free),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_frame_length  (o_frame_length),
        .o_byte_position (o_byte_position),
        .o_payload_byte  (o_payload_byte),
        .o_last_of_frame (o_last_of_frame)
    );

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp_len <= LEN_W'(MAX_PAYLOAD))
        else $error("expected length exceeds the payload store depth");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DATA) |-> (r_cnt < r_exp_len))
        else $error("payload count reached the length while still receiving data");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_LOAD))
        else $error("result request appeared outside the readout");

    a_read_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && r_exp_len != '0) |-> (r_idx < r_exp_len))
        else $error("readout index ran past the frame length");
`endif

endmodule

// File: sim/tb_serial_frame_deframer.sv
// Self-checking testbench for serial_frame_deframer: directed and random byte streams,
// register changes over the APB port and randomized valid/stall on both channels.
// Depends on sfd_pkg and the serial_frame_deframer RTL.
`timescale 1ns / 1ps

module tb_serial_frame_deframer;

    import sfd_pkg::*;

    localparam int SETTLE_CYCLES = 10;

    class frame_checker;
        logic [BYTE_W-1:0] marker;
        logic [LEN_W-1:0]  max_len;
        t_state            phase;
        logic [LEN_W-1:0]  want_len;
        logic [LEN_W-1:0]  got_len;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] payload [MAX_PAYLOAD];
        t_result           results_due [$];
        int                mismatch_count;
        int                results_checked;
        int                frames_accepted;

        function new();
            marker          = START_MARKER_RESET;
            max_len         = MAX_LENGTH_RESET;
            phase           = ST_HUNT;
            want_len        = '0;
            got_len         = '0;
            sum             = '0;
            mismatch_count  = 0;
            results_checked = 0;
            frames_accepted = 0;
        endfunction

        function void set_register(t_reg_index idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_START_MARKER: marker = value[BYTE_W-1:0];
                REG_MAX_LENGTH:   max_len = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int length_limit();
            return (max_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(max_len);
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void take_rx_byte(logic [BYTE_W-1:0] b);
            t_result r;
            int      i;
            case (phase)
                ST_HUNT: begin
                    if (b == marker)
                        phase = ST_LENGTH;
                end
                ST_LENGTH: begin
                    if (b > length_limit()) begin
                        phase = ST_HUNT;
                    end else begin
                        want_len = b[LEN_W-1:0];
                        got_len  = '0;
                        sum      = '0;
                        phase    = (b == 0) ? ST_CHECK : ST_DATA;
                    end
                end
                ST_DATA: begin
                    payload[got_len[ADDR_W-1:0]] = b;
                    sum     = sum + b;
                    got_len = got_len + 1'b1;
                    if (got_len >= want_len)
                        phase = ST_CHECK;
                end
                default: begin
                    if (b == sum) begin
                        frames_accepted++;
                        if (want_len == 0) begin
                            r.frame_length  = '0;
                            r.byte_position = '0;
                            r.payload_byte  = '0;
                            r.last_of_frame = 1'b1;
                            results_due.push_back(r);
                        end else begin
                            for (i = 0; i < want_len; i++) begin
                                r.frame_length  = want_len;
                                r.byte_position = i[ADDR_W-1:0];
                                r.payload_byte  = payload[i];
                                r.last_of_frame = (i + 1 == want_len);
                                results_due.push_back(r);
                            end
                        end
                    end
                    phase = ST_HUNT;
                end
            endcase
        endfunction

        function void note_mismatch(string what, t_result want, t_result got);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t MISMATCH %s: expected len=%0d pos=%0d byte=%02h last=%0b",
                         $time, what, want.frame_length, want.byte_position,
                         want.payload_byte, want.last_of_frame);
            if (mismatch_count <= 10)
                $display("%0t          got      len=%0d pos=%0d byte=%02h last=%0b",
                         $time, got.frame_length, got.byte_position,
                         got.payload_byte, got.last_of_frame);
        endfunction

        function void check_payload_result(t_result got);
            t_result want;
            results_checked++;
            if (results_due.size() == 0) begin
                note_mismatch("result with none expected", '0, got);
            end else begin
                want = results_due.pop_front();
                if (got.frame_length !== want.frame_length ||
                    got.byte_position !== want.byte_position ||
                    got.payload_byte !== want.payload_byte ||
                    got.last_of_frame !== want.last_of_frame)
                    note_mismatch("payload result", want, got);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                i_rx_valid;
    logic                o_rx_stall;
    logic [BYTE_W-1:0]   i_rx_byte;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [LEN_W-1:0]    o_frame_length;
    logic [ADDR_W-1:0]   o_byte_position;
    logic [BYTE_W-1:0]   o_payload_byte;
    logic                o_last_of_frame;

    frame_checker board;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           bytes_sent;

    serial_frame_deframer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_rx_valid      (i_rx_valid),
        .o_rx_stall      (o_rx_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_frame_length  (o_frame_length),
        .o_byte_position (o_byte_position),
        .o_payload_byte  (o_payload_byte),
        .o_last_of_frame (o_last_of_frame)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("serial_frame_deframer test failed");
        $finish;
    end

    initial begin
        t_result got;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.frame_length  = o_frame_length;
                got.byte_position = o_byte_position;
                got.payload_byte  = o_payload_byte;
                got.last_of_frame = o_last_of_frame;
                board.check_payload_result(got);
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        board.take_rx_byte(b);
        bytes_sent++;
    endtask

    // The sender holds off until every pending result has been taken, then waits a settle period.
    task automatic wait_results_drained();
        i_rx_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_index idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(idx, value);
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [BYTE_W-1:0] marker, input logic [LEN_W-1:0] max_len);
        wait_results_drained();
        apb_write(REG_START_MARKER, PDATA_W'(marker));
        apb_write(REG_MAX_LENGTH, PDATA_W'(max_len));
    endtask

    task automatic run_random_traffic(input int n_bytes);
        int                start_count;
        int                kind;
        int                lim;
        int                len;
        int                k;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] ck;
        start_count = bytes_sent;
        while (bytes_sent - start_count < n_bytes) begin
            while (board.phase != ST_HUNT)
                send_byte(8'($urandom_range(255)));
            lim  = board.length_limit();
            kind = $urandom_range(99);
            if (kind < 70) begin
                if ($urandom_range(9) == 0)
                    len = lim;
                else
                    len = $urandom_range((lim < 8) ? lim : 8);
                send_byte(board.marker);
                send_byte(8'(len));
                ck = '0;
                for (k = 0; k < len; k++) begin
                    b  = 8'($urandom_range(255));
                    ck = ck + b;
                    send_byte(b);
                end
                if ($urandom_range(99) < 15)
                    ck = ck ^ 8'($urandom_range(255, 1));
                send_byte(ck);
            end else if (kind < 80) begin
                send_byte(board.marker);
                send_byte(8'($urandom_range(255, lim + 1)));
            end else if (kind < 90) begin
                repeat ($urandom_range(6, 1))
                    send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(board.marker);
                send_byte(8'($urandom_range(lim)));
                repeat ($urandom_range(3))
                    send_byte(8'($urandom_range(255)));
            end
            if ($urandom_range(24) == 0)
                wait_results_drained();
        end
    endtask

    initial begin
        board         = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        bytes_sent    = 0;
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_rx_valid <= 1'b0;
        i_rx_byte  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 22;
        recv_idle_pct = 51;

        // Directed part with reset register values: noise, empty frames, rejected lengths,
        // the marker value carried as data and as checksum, and a bad checksum.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_MARKER_RESET);
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(START_MARKER_RESET);
        send_byte(8'd0);
        send_byte(8'd1);
        send_byte(START_MARKER_RESET);
        send_byte(8'd33);
        send_byte(START_MARKER_RESET);
        send_byte(8'hFF);
        send_byte(START_MARKER_RESET);
        send_byte(8'd2);
        send_byte(8'hFF);
        send_byte(START_MARKER_RESET);
        send_byte(8'h54);
        send_byte(START_MARKER_RESET);
        send_byte(8'd1);
        send_byte(START_MARKER_RESET);
        send_byte(START_MARKER_RESET);
        send_byte(START_MARKER_RESET);
        send_byte(8'd1);
        send_byte(8'h80);
        send_byte(8'h81);

        configure(8'hFF, 6'd32);
        run_random_traffic(60);
        configure(8'h00, 6'd0);
        run_random_traffic(60);

        send_idle_pct = 51;
        recv_idle_pct = 22;
        configure(8'hA5, 6'd7);
        run_random_traffic(60);
        configure(8'h3C, 6'd1);
        run_random_traffic(60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(START_MARKER_RESET, MAX_LENGTH_RESET);
        run_random_traffic(60);

        wait_results_drained();

        $display("Streamed %0d received bytes through five marker/length settings,", bytes_sent);
        $display("accepting %0d frames and checking %0d payload results.",
                 board.frames_accepted, board.results_checked);
        if (board.mismatch_count == 0 && board.pending() == 0) begin
            $display("serial_frame_deframer test passed");
        end else begin
            $display("serial_frame_deframer test failed");
        end
        $finish;
    end

endmodule
